// ===== sv/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg: shared types and codes for the sharded counter bank
// Payload words of both channels, command and status codes, and the decoded
// job word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package scb_pkg;

  // command codes of the input word
  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_PUT = 2'd2;

  // status codes of the result word
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_BAD_SHARD = 2'd2;

  localparam int unsigned CFG_W       = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        counter_index;
    logic [3:0]         shard;
    logic signed [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } out_word_t;

  // decoded operation for the back end
  typedef enum logic [1:0] {
    OP_NOP,
    OP_GET,
    OP_ADD,
    OP_PUT
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  status;
    logic [3:0]  shard;
    logic [63:0] value;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

endpackage

// ===== sv/scb_front.sv =====
// ----------------------------------------------------------------------------
// scb_front: input word classification
// Holds the counters-in-use register, checks index and shard, and turns each
// accepted word into a job plus the base address of its counter row.
// ----------------------------------------------------------------------------
module scb_front import scb_pkg::*; #(
  parameter int MAX_COUNTERS = 256,
  parameter int SHARDS       = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  busy_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output job_t                  job_o,
  output logic [$clog2(MAX_COUNTERS*(SHARDS+1))-1:0] base_o
);

  localparam int SLOTS = SHARDS + 1;
  localparam int AW    = $clog2(MAX_COUNTERS * SLOTS);
  localparam int RW    = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;

  logic [CFG_W-1:0] cfg_q;
  logic             bad_index;
  logic             bad_shard;
  logic [RW-1:0]    row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i && !busy_i;
  assign q_push_o    = in_valid_i && in_ready_o;

  assign bad_index = (in_data_i.counter_index == 16'd0)
                  || ({1'b0, in_data_i.counter_index} > 17'(cfg_q))
                  || ({1'b0, in_data_i.counter_index} > 17'(MAX_COUNTERS));
  assign bad_shard = (in_data_i.shard == 4'd0)
                  || ({1'b0, in_data_i.shard} > 5'(SHARDS));
  assign row       = RW'(in_data_i.counter_index - 16'd1);
  assign base_o    = AW'(AW'(row) * AW'(SLOTS));

  always_comb begin
    job_o.op     = OP_NOP;
    job_o.status = STAT_OK;
    job_o.shard  = in_data_i.shard;
    job_o.value  = in_data_i.value;
    case (in_data_i.command)
      CMD_GET, CMD_ADD, CMD_PUT: begin
        if (bad_index) begin
          job_o.status = STAT_BAD_INDEX;
        end else if (in_data_i.command == CMD_GET) begin
          job_o.op = OP_GET;
        end else if (in_data_i.command == CMD_PUT) begin
          job_o.op = OP_PUT;
        end else if (bad_shard) begin
          job_o.status = STAT_BAD_SHARD;
        end else begin
          job_o.op = OP_ADD;
        end
      end
      default: begin
        job_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== sv/scb_fifo.sv =====
// ----------------------------------------------------------------------------
// scb_fifo: two-entry job queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module scb_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int DEPTH = 2;

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;

  assign full_o     = (count_q == 2'(DEPTH));
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== sv/scb_back.sv =====
// ----------------------------------------------------------------------------
// scb_back: slot memory and job sequencer
// Clears the slot memory after reset, then runs one job at a time: sweep the
// needed slots through the single read port, sum them, write back and post
// the result word into the output register.
// ----------------------------------------------------------------------------
module scb_back import scb_pkg::*; #(
  parameter int MAX_COUNTERS = 256,
  parameter int SHARDS       = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output logic                  busy_o,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  job_t                  job_i,
  input  logic [$clog2(MAX_COUNTERS*(SHARDS+1))-1:0] base_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o
);

  localparam int SLOTS = SHARDS + 1;
  localparam int DEPTH = MAX_COUNTERS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [63:0]   mem [DEPTH];

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  job_t          job_q, job_d;
  logic [AW-1:0] base_q, base_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] end_q, end_d;
  logic [63:0]   acc_q;
  logic          rd_vld_q;
  logic [63:0]   rd_data_q;
  logic          out_valid_q;
  out_word_t     out_data_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          out_free;
  logic          out_load;

  assign out_free    = !out_valid_q || out_ready_i;
  assign busy_o      = (state_q == S_CLEAR);
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_load    = (state_q == S_DONE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    job_d      = job_q;
    base_d     = base_q;
    slot_d     = slot_q;
    end_d      = end_q;
    rd_en      = 1'b0;
    rd_addr    = base_q + AW'(slot_q);
    mem_we     = 1'b0;
    wr_addr    = clr_addr_q;
    wr_data    = 64'd0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          job_d  = job_i;
          base_d = base_i;
          end_d  = SW'(SHARDS);
          state_d = S_SCAN;
          case (job_i.op)
            OP_GET: slot_d = SW'(0);
            OP_PUT: slot_d = SW'(1);
            OP_ADD: begin
              slot_d = SW'(job_i.shard);
              end_d  = SW'(job_i.shard);
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (slot_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          slot_d = slot_q + SW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (job_q.op == OP_ADD) begin
            mem_we  = 1'b1;
            wr_addr = base_q + AW'(end_q);
            wr_data = acc_q + job_q.value;
          end else if (job_q.op == OP_PUT) begin
            mem_we  = 1'b1;
            wr_addr = base_q;
            wr_data = job_q.value - acc_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      rd_vld_q   <= rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    base_q <= base_d;
    slot_q <= slot_d;
    end_q  <= end_d;
    if (q_pop_o) begin
      acc_q <= 64'd0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + rd_data_q;
    end
    if (out_load) begin
      out_data_q.result_value <= (job_q.op == OP_GET) ? acc_q : 64'd0;
      out_data_q.status       <= job_q.status;
    end
  end

`ifndef SYNTH
  a_done_no_pending_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> !rd_vld_q)
    else $error("read still in flight when job completes");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == S_SCAN)
    else $error("read data returned without a slot sweep");

  a_writeback_posts_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_DONE) |=> out_valid_q)
    else $error("slot write-back without a result word");

  a_word_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result word posted outside job completion");
`endif

endmodule

// ===== sv/sharded_counter_bank_top.sv =====
// ----------------------------------------------------------------------------
// sharded_counter_bank_top: bank of 64-bit counters split into shard slots
// Top level: front end, job queue and back end with the slot memory.
// ----------------------------------------------------------------------------
// Each counter is one base slot plus SHARDS shard slots in a single-port-read
// slot memory. An add updates its own shard slot, a get returns the wrapped
// sum of all slots, a put rewrites the base so a later get returns the value.
// Every accepted word yields exactly one result word. The one read port of
// the slot memory is swept one slot per cycle: a get sweeps the base and
// every shard slot, a put the shard slots and an add only its own shard
// slot; a rejected or unused command sweeps none. The result word may wait
// on out_ready_i. A two-word queue lets the front end keep accepting while
// the back end works or while a result waits. After reset the block zeroes
// the slot memory one word per cycle and holds in_ready_o low until done;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module sharded_counter_bank_top import scb_pkg::*; #(
  parameter int MAX_COUNTERS = 256,
  parameter int SHARDS       = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // address width of the slot memory
  localparam int AW = $clog2(MAX_COUNTERS * (SHARDS + 1));
  localparam int QW = JOB_W + AW;

  logic          busy;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  job_t          push_job;
  logic [AW-1:0] push_base;
  logic [QW-1:0] pop_word;
  job_t          pop_job;
  logic [AW-1:0] pop_base;

  // classify each word: index and shard checks, row base address
  scb_front #(
    .MAX_COUNTERS(MAX_COUNTERS),
    .SHARDS      (SHARDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .busy_i     (busy),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .job_o      (push_job),
    .base_o     (push_base)
  );

  // hold decoded jobs between the two halves
  scb_fifo #(
    .DATA_W(QW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({push_job, push_base}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_word)
  );

  assign pop_job  = job_t'(pop_word[QW-1:AW]);
  assign pop_base = pop_word[AW-1:0];

  // sweep slots, sum, write back, post result word
  scb_back #(
    .MAX_COUNTERS(MAX_COUNTERS),
    .SHARDS      (SHARDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (busy),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .job_i      (pop_job),
    .base_i     (pop_base),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sharded counter bank
// Drives command words through valid/ready with bursty gaps, stalls the result
// side on shifting patterns, mirrors the slot store and the counter limit in
// a local model, and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import scb_pkg::*;

  localparam int MAX_COUNTERS = 256;
  localparam int SHARDS       = 8;

  // command 3 has no name in the package; the block must answer it as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int          PHASE_WORDS   = 230;

  localparam logic [63:0] VAL_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_word_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_word_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  // local copy of the slot store and the counter limit
  bit [63:0]   slot_model [MAX_COUNTERS][SHARDS+1];
  bit [CFG_W-1:0] limit_model = CFG_RESET;

  out_word_t   expected_results [$];
  out_word_t   want;
  int          err_count   = 0;
  int unsigned cycle_count = 0;

  // sender burst state
  int burst_left = 0;

  // receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;

  sharded_counter_bank_top #(
    .MAX_COUNTERS(MAX_COUNTERS),
    .SHARDS      (SHARDS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop: covers the post-reset clearing sweep plus every word at its
  // slowest (get sweep, longest sender gap, longest receiver stall) many
  // times over.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("[cycle %0d] %s", cycle_count, msg);
    err_count++;
  endtask

  // Effective limit: values beyond the bank size act as the bank size.
  function automatic int unsigned active_counters();
    return (limit_model > MAX_COUNTERS) ? MAX_COUNTERS : limit_model;
  endfunction

  // Work out the result word of one command and apply its effect on the store.
  function automatic out_word_t predict_counter(in_word_t w);
    out_word_t   r;
    int unsigned row;
    bit [63:0]   shard_total;
    r.result_value = '0;
    r.status       = STAT_OK;
    if (w.command == CMD_UNUSED) return r;
    if (w.counter_index == 0 || w.counter_index > active_counters()) begin
      r.status = STAT_BAD_INDEX;
      return r;
    end
    row         = w.counter_index - 1;
    shard_total = '0;
    for (int s = 1; s <= SHARDS; s++) shard_total += slot_model[row][s];
    case (w.command)
      CMD_GET: r.result_value = slot_model[row][0] + shard_total;
      CMD_ADD: begin
        if (w.shard == 0 || w.shard > SHARDS) r.status = STAT_BAD_SHARD;
        else slot_model[row][w.shard] += w.value;
      end
      CMD_PUT: slot_model[row][0] = w.value - shard_total;
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, int unsigned idx,
                                         int unsigned shard, logic [63:0] val);
    in_word_t w;
    w.command       = cmd;
    w.counter_index = idx[15:0];
    w.shard         = shard[3:0];
    w.value         = val;
    return w;
  endfunction

  // Send one command word. Gaps only open at the start of a burst, so valid
  // never drops and rises within one time step.
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_counter(w));
  endtask

  // Drop valid and wait until every result is back, then let the pipe settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_model = v;
    @(posedge clk_i);
  endtask

  // Check each accepted result word, then pick the next stall decision.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result word value=%h status=%0d",
                         out_data_o.result_value, out_data_o.status));
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.result_value !== want.result_value)
          report($sformatf("result_value %h, want %h",
                           out_data_o.result_value, want.result_value));
        if (out_data_o.status !== want.status)
          report($sformatf("status %0d, want %0d", out_data_o.status, want.status));
      end
    end
    // Rotate between always-ready, coin-flip, sparse and full-stall stretches.
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= 1'b0;
    endcase
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MAX_POS;
      1:       return VAL_MIN_NEG;
      2:       return VAL_ALL_ONE;
      3:       return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly valid indices with a hot set at the bottom so sums build up;
  // the rest hit zero, the first index past the limit, or anything above.
  function automatic int unsigned rand_index();
    int unsigned lim;
    int unsigned pick;
    lim  = active_counters();
    pick = $urandom_range(0, 99);
    if (lim == 0) return $urandom_range(0, 65535);
    if (pick < 4)  return 0;
    if (pick < 7)  return lim + 1;
    if (pick < 10) return $urandom_range(lim + 1, 65535);
    if (pick < 60) return $urandom_range(1, (lim < 6) ? lim : 6);
    return $urandom_range(1, lim);
  endfunction

  function automatic logic [1:0] rand_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) return CMD_GET;
    if (pick < 72) return CMD_ADD;
    if (pick < 96) return CMD_PUT;
    return CMD_UNUSED;
  endfunction

  // Edge cases at the reset limit: empty get, signed extremes, every bad
  // shard kind, bad index taking priority over bad shard, wraparound, put
  // followed by get, and the unused command.
  task automatic test_directed();
    send_word(make_word(CMD_GET,    1,     0,  '0));
    send_word(make_word(CMD_ADD,    1,     1,  VAL_MAX_POS));
    send_word(make_word(CMD_ADD,    1,     SHARDS, VAL_MIN_NEG));
    send_word(make_word(CMD_ADD,    1,     0,  64'd5));
    send_word(make_word(CMD_ADD,    1,     SHARDS + 1, 64'd5));
    send_word(make_word(CMD_ADD,    1,     15, 64'd5));
    send_word(make_word(CMD_ADD,    0,     0,  64'd5));
    send_word(make_word(CMD_GET,    1,     0,  '0));
    send_word(make_word(CMD_ADD,    1,     2,  64'd1));
    send_word(make_word(CMD_GET,    1,     15, VAL_ALL_ONE));
    send_word(make_word(CMD_PUT,    1,     7,  64'h0123_4567_89AB_CDEF));
    send_word(make_word(CMD_GET,    1,     0,  '0));
    send_word(make_word(CMD_PUT,    256,   0,  VAL_MIN_NEG));
    send_word(make_word(CMD_ADD,    256,   SHARDS, VAL_ALL_ONE));
    send_word(make_word(CMD_GET,    256,   0,  '0));
    send_word(make_word(CMD_GET,    257,   0,  '0));
    send_word(make_word(CMD_PUT,    65535, 15, VAL_ALL_ONE));
    send_word(make_word(CMD_UNUSED, 0,     15, VAL_ALL_ONE));
    send_word(make_word(CMD_UNUSED, 1,     1,  64'd9));
  endtask

  // Limit extremes: zero rejects all, one, above the bank size, all bits set.
  task automatic test_limits();
    set_limit(9'd0);
    send_word(make_word(CMD_GET, 1, 0, '0));
    send_word(make_word(CMD_ADD, 1, 1, 64'd3));
    set_limit(9'd1);
    send_word(make_word(CMD_GET, 1, 0, '0));
    send_word(make_word(CMD_GET, 2, 0, '0));
    set_limit(9'd511);
    send_word(make_word(CMD_GET, 256, 0, '0));
    send_word(make_word(CMD_GET, 257, 0, '0));
    set_limit(9'd300);
    send_word(make_word(CMD_ADD, 256, 3, 64'd2));
    send_word(make_word(CMD_GET, 256, 0, '0));
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] phase_limit [7];
    phase_limit = '{9'd256, 9'd5, 9'd511, 9'd1, 9'($urandom_range(2, 255)),
                    9'd257, 9'd256};
    foreach (phase_limit[p]) begin
      set_limit(phase_limit[p]);
      repeat (PHASE_WORDS) begin
        send_word(make_word(rand_command(), rand_index(),
                            ($urandom_range(0, 99) < 85) ? $urandom_range(1, SHARDS)
                                                         : $urandom_range(0, 15),
                            rand_value()));
      end
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_limits();
    test_random();

    wait_idle();
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
